>>> hw/rtl/orcs_pkg.sv
// Shared codes and widths for the sprite attribute row store.
package orcs_pkg;

  localparam int unsigned KindW     = 2;
  localparam int unsigned ByteIdxW  = 8;
  localparam int unsigned DataW     = 8;
  localparam int unsigned CtypeW    = 2;
  localparam int unsigned DotW      = 7;
  localparam int unsigned RowIdxW   = 5;
  localparam int unsigned RowBitsW  = 64;
  localparam int unsigned WordW     = 16;

  // Item kinds
  localparam logic [KindW-1:0] KindRead    = 2'd0;
  localparam logic [KindW-1:0] KindWrite   = 2'd1;
  localparam logic [KindW-1:0] KindCorrupt = 2'd2;

  // Corruption types
  localparam logic [CtypeW-1:0] CtWrite   = 2'd0;
  localparam logic [CtypeW-1:0] CtRead    = 2'd1;
  localparam logic [CtypeW-1:0] CtReadInc = 2'd2;

  // Internal operation after decode
  typedef enum logic [1:0] {
    OpNone    = 2'd0,
    OpRead    = 2'd1,
    OpWrite   = 2'd2,
    OpCorrupt = 2'd3
  } op_e;

  localparam logic [DataW-1:0] LockedByte = 8'hFF;

endpackage

>>> hw/rtl/orcs_if.sv
// Request and response channel interfaces of the sprite attribute row store.
interface orcs_req_if;
  logic                             valid;
  logic                             ready;
  logic [orcs_pkg::KindW-1:0]       kind;
  logic [orcs_pkg::ByteIdxW-1:0]    byte_index;
  logic [orcs_pkg::DataW-1:0]       write_byte;
  logic                             bus_locked;
  logic [orcs_pkg::CtypeW-1:0]      corrupt_type;
  logic                             scan_active;
  logic [orcs_pkg::DotW-1:0]        line_dot;

  modport source (
    output valid, kind, byte_index, write_byte, bus_locked, corrupt_type, scan_active,
           line_dot,
    input  ready
  );
  modport sink (
    input  valid, kind, byte_index, write_byte, bus_locked, corrupt_type, scan_active,
           line_dot,
    output ready
  );
endinterface

interface orcs_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [orcs_pkg::DataW-1:0] read_byte;

  modport source (output valid, read_byte, input ready);
  modport sink (input valid, read_byte, output ready);
endinterface

>>> hw/rtl/oam_row_corruption_store_unit.sv
// Sprite attribute row store: 160 bytes as 64-bit rows, byte access and scan corruption.
//
// Channels: req_i (sink) takes one item per handshake: a byte read, a byte write
// or a corruption event; rsp_o (source) returns exactly one read_byte per item,
// in order. A locked or out-of-range read returns 0xFF; all other kinds return 0.
// The rows live in a simple dual-port synchronous memory (one read, one write per
// cycle, registered read data). A byte read reads its row; a byte write reads its
// row and writes it back with the new byte. Items that change nothing, a locked or
// out-of-range read included, leave the rows alone. A write or read corruption
// reads the row above and the row itself, then writes the merged row; a corruption
// during increment on rows 4 to ROW_COUNT-2 makes three row reads, then three row
// writes of the merged row, and on other rows takes the read corruption path. The
// row reads go one by one through the one memory read port.
// req_i.ready is high only while no item is in flight; the result sits in an
// output register, so the next item is taken while it waits. If rsp_o stalls with
// a result still held, a finished item waits before loading its result.
// Reset: every row reads as zero after reset through per-row valid bits, so no
// clearing pass is needed; the block accepts an item as soon as reset is released.
module oam_row_corruption_store_unit #(
  parameter int unsigned ROW_COUNT = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  orcs_req_if.sink   req_i,
  orcs_rsp_if.source rsp_o
);

  localparam int unsigned RowW = $clog2(ROW_COUNT);
  localparam logic [orcs_pkg::ByteIdxW:0] StoreBytes = (orcs_pkg::ByteIdxW + 1)'(ROW_COUNT * 8);
  localparam logic [orcs_pkg::RowIdxW-1:0] RowLimit = orcs_pkg::RowIdxW'(ROW_COUNT);
  localparam logic [orcs_pkg::RowIdxW-1:0] DeepLimit = orcs_pkg::RowIdxW'(ROW_COUNT - 1);
  localparam logic [orcs_pkg::RowIdxW-1:0] DeepFirst = 5'd4;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StRdA  = 4'd1;
  localparam logic [3:0] StByte = 4'd2;
  localparam logic [3:0] StRdB  = 4'd3;
  localparam logic [3:0] StRdC  = 4'd4;
  localparam logic [3:0] StCw   = 4'd5;
  localparam logic [3:0] StDw   = 4'd6;
  localparam logic [3:0] StDw2  = 4'd7;
  localparam logic [3:0] StDw3  = 4'd8;
  localparam logic [3:0] StFin  = 4'd9;

  logic [3:0] state_q, state_d;

  orcs_pkg::op_e                   op_q, dec_op;
  logic [orcs_pkg::RowIdxW-1:0]    row_q, dec_row, dot_row, row_p, row_pp;
  logic [2:0]                      sel_q;
  logic [orcs_pkg::DataW-1:0]      wdata_q, res_q, dec_res;
  logic [orcs_pkg::CtypeW-1:0]     ctype_q;
  logic                            deep_q, dec_deep, dec_inside;
  logic [orcs_pkg::RowBitsW-1:0]   p_q, r_q;

  logic                            rsp_valid_q;
  logic [orcs_pkg::DataW-1:0]      rsp_byte_q;
  logic                            accept, fin_go;

  // Row memory
  logic [orcs_pkg::RowBitsW-1:0]   mem [ROW_COUNT];
  logic [ROW_COUNT-1:0]            row_vld_q;
  logic [RowW-1:0]                 mem_raddr, mem_waddr;
  logic                            mem_we;
  logic [orcs_pkg::RowBitsW-1:0]   mem_wdata, mem_rd_q, rdata;
  logic                            rd_vld_q;

  logic [7:0][7:0]                 rd_lanes, wr_lanes;
  logic [orcs_pkg::WordW-1:0]      ca, cb, cc, cd, cur_w0, mid_w0;
  logic [orcs_pkg::RowBitsW-1:0]   new_p;

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == StIdle);
  assign fin_go      = !rsp_valid_q || rsp_o.ready;
  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.read_byte = rsp_byte_q;

  // Decode the incoming item
  assign dot_row    = req_i.line_dot[orcs_pkg::DotW-1:2];
  assign dec_inside = {1'b0, req_i.byte_index} < StoreBytes;

  always_comb begin
    dec_op  = orcs_pkg::OpNone;
    dec_res = '0;
    dec_row = req_i.byte_index[orcs_pkg::ByteIdxW-1:3];
    case (req_i.kind)
      orcs_pkg::KindRead: begin
        if (req_i.bus_locked || !dec_inside) begin
          dec_res = orcs_pkg::LockedByte;
        end else begin
          dec_op = orcs_pkg::OpRead;
        end
      end
      orcs_pkg::KindWrite: begin
        if (!req_i.bus_locked && dec_inside) begin
          dec_op = orcs_pkg::OpWrite;
        end
      end
      orcs_pkg::KindCorrupt: begin
        dec_row = dot_row;
        if (req_i.scan_active && dot_row != '0 && dot_row < RowLimit &&
            (req_i.corrupt_type == orcs_pkg::CtWrite ||
             req_i.corrupt_type == orcs_pkg::CtRead ||
             req_i.corrupt_type == orcs_pkg::CtReadInc)) begin
          dec_op = orcs_pkg::OpCorrupt;
        end
      end
      default: begin
        dec_op = orcs_pkg::OpNone;
      end
    endcase
  end

  assign dec_deep = (req_i.corrupt_type == orcs_pkg::CtReadInc) &&
                    (dot_row >= DeepFirst) && (dot_row < DeepLimit);

  assign row_p  = row_q - 5'd1;
  assign row_pp = row_q - 5'd2;

  // Rows never written since reset read as zero
  assign rdata    = rd_vld_q ? mem_rd_q : '0;
  assign rd_lanes = rdata;

  always_comb begin
    wr_lanes = rd_lanes;
    wr_lanes[sel_q] = wdata_q;
  end

  // Corruption words
  assign ca = rdata[orcs_pkg::WordW-1:0];
  assign cb = p_q[orcs_pkg::WordW-1:0];
  assign cc = p_q[3*orcs_pkg::WordW-1:2*orcs_pkg::WordW];
  assign cd = r_q[orcs_pkg::WordW-1:0];
  assign cur_w0 = (ctype_q == orcs_pkg::CtWrite) ? (((ca ^ cc) & (cb ^ cc)) ^ cc)
                                                 : (cb | (ca & cc));
  // During increment: a = row before previous, b = previous, c = previous word 2, d = current
  assign mid_w0 = (cb & (ca | cd | cc)) | (ca & cd & cc);
  assign new_p  = {p_q[orcs_pkg::RowBitsW-1:orcs_pkg::WordW], mid_w0};

  // Sequencer
  always_comb begin
    state_d   = state_q;
    mem_raddr = row_q[RowW-1:0];
    mem_waddr = row_q[RowW-1:0];
    mem_we    = 1'b0;
    mem_wdata = {wr_lanes};
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = (dec_op == orcs_pkg::OpNone) ? StFin : StRdA;
        end
      end
      StRdA: begin
        if (op_q == orcs_pkg::OpCorrupt) begin
          mem_raddr = row_p[RowW-1:0];
          state_d   = StRdB;
        end else begin
          state_d   = StByte;
        end
      end
      StByte: begin
        mem_we  = (op_q == orcs_pkg::OpWrite);
        state_d = StFin;
      end
      StRdB: begin
        state_d = deep_q ? StRdC : StCw;
      end
      StRdC: begin
        mem_raddr = row_pp[RowW-1:0];
        state_d   = StDw;
      end
      StCw: begin
        mem_we    = 1'b1;
        mem_wdata = {p_q[orcs_pkg::RowBitsW-1:orcs_pkg::WordW], cur_w0};
        state_d   = StFin;
      end
      StDw: begin
        mem_we    = 1'b1;
        mem_waddr = row_p[RowW-1:0];
        mem_wdata = new_p;
        state_d   = StDw2;
      end
      StDw2: begin
        mem_we    = 1'b1;
        mem_wdata = p_q;
        state_d   = StDw3;
      end
      StDw3: begin
        mem_we    = 1'b1;
        mem_waddr = row_pp[RowW-1:0];
        mem_wdata = p_q;
        state_d   = StFin;
      end
      StFin: begin
        if (fin_go) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rsp_valid_q <= 1'b0;
      row_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= row_vld_q[mem_raddr];
      if (mem_we) begin
        row_vld_q[mem_waddr] <= 1'b1;
      end
      if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (state_q == StFin && fin_go) begin
        rsp_valid_q <= 1'b1;
      end
    end
  end

  // Item payload and working rows
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= dec_op;
      row_q   <= dec_row;
      sel_q   <= req_i.byte_index[2:0];
      wdata_q <= req_i.write_byte;
      ctype_q <= req_i.corrupt_type;
      deep_q  <= dec_deep;
      res_q   <= dec_res;
    end
    if (state_q == StByte && op_q == orcs_pkg::OpRead) begin
      res_q <= rd_lanes[sel_q];
    end
    if (state_q == StRdB) begin
      p_q <= rdata;
    end
    if (state_q == StRdC) begin
      r_q <= rdata;
    end
    if (state_q == StDw) begin
      p_q <= new_p;
    end
    if (state_q == StFin && fin_go) begin
      rsp_byte_q <= res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rd_q <= mem[mem_raddr];
  end

  // Checks
  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (mem_waddr < RowW'(ROW_COUNT)))
    else $error("row write beyond the store");

  a_no_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |=> $stable(row_vld_q) || $past(accept))
    else $error("row written with no item in flight");

  a_deep_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDw |=> state_q == StDw2 ##1 state_q == StDw3 ##1 state_q == StFin)
    else $error("increment corruption write sequence broken");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin && fin_go) |=> rsp_o.valid && rsp_o.read_byte == $past(res_q)
      && state_q == StIdle)
    else $error("result not loaded on finish");

  a_byte_op_no_corrupt_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StByte) |-> (op_q == orcs_pkg::OpRead || op_q == orcs_pkg::OpWrite))
    else $error("byte state entered for a non-byte item");

endmodule

>>> verif/orcs_row_checker.sv
// Checker for the sprite attribute row store: mirrors the rows and compares every returned byte.
`timescale 1ns / 1ps
module orcs_row_checker #(
  parameter int unsigned ROW_COUNT = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  orcs_req_if         req_i,
  orcs_rsp_if         rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [orcs_pkg::RowBitsW-1:0] shadow_rows [ROW_COUNT];
  logic [orcs_pkg::DataW-1:0]    expected_bytes [$];
  int unsigned                   mismatches = 0;
  int unsigned                   results_seen = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t: result %0d: %s", $time, results_seen, msg);
    mismatches++;
  endtask

  // Read-time merge of the scanned row with the row above it.
  task automatic merge_read_row(input int r);
    logic [orcs_pkg::WordW-1:0] a, b, c;
    a = shadow_rows[r][orcs_pkg::WordW-1:0];
    b = shadow_rows[r-1][orcs_pkg::WordW-1:0];
    c = shadow_rows[r-1][3*orcs_pkg::WordW-1:2*orcs_pkg::WordW];
    shadow_rows[r] = {shadow_rows[r-1][orcs_pkg::RowBitsW-1:orcs_pkg::WordW], b | (a & c)};
  endtask

  // Advance the mirrored rows by one item and work out the byte it returns.
  task automatic apply_item(output logic [orcs_pkg::DataW-1:0] rd);
    logic [orcs_pkg::WordW-1:0] a, b, c, d;
    int                         r;
    int                         dot_row;
    logic                       in_store;
    rd       = '0;
    r        = int'(req_i.byte_index >> 3);
    dot_row  = int'(req_i.line_dot >> 2);
    in_store = req_i.byte_index < ROW_COUNT * 8;
    case (req_i.kind)
      orcs_pkg::KindRead: begin
        if (req_i.bus_locked || !in_store) begin
          rd = orcs_pkg::LockedByte;
        end else begin
          rd = shadow_rows[r][8*req_i.byte_index[2:0] +: orcs_pkg::DataW];
        end
      end
      orcs_pkg::KindWrite: begin
        if (!req_i.bus_locked && in_store) begin
          shadow_rows[r][8*req_i.byte_index[2:0] +: orcs_pkg::DataW] = req_i.write_byte;
        end
      end
      orcs_pkg::KindCorrupt: begin
        // The top row and rows past the scan phase are left alone.
        if (req_i.scan_active && dot_row != 0 && dot_row < ROW_COUNT) begin
          case (req_i.corrupt_type)
            orcs_pkg::CtWrite: begin
              a = shadow_rows[dot_row][orcs_pkg::WordW-1:0];
              b = shadow_rows[dot_row-1][orcs_pkg::WordW-1:0];
              c = shadow_rows[dot_row-1][3*orcs_pkg::WordW-1:2*orcs_pkg::WordW];
              shadow_rows[dot_row] =
                {shadow_rows[dot_row-1][orcs_pkg::RowBitsW-1:orcs_pkg::WordW],
                 ((a ^ c) & (b ^ c)) ^ c};
            end
            orcs_pkg::CtRead: merge_read_row(dot_row);
            orcs_pkg::CtReadInc: begin
              if (dot_row >= 4 && dot_row < ROW_COUNT - 1) begin
                a = shadow_rows[dot_row-2][orcs_pkg::WordW-1:0];
                b = shadow_rows[dot_row-1][orcs_pkg::WordW-1:0];
                c = shadow_rows[dot_row][orcs_pkg::WordW-1:0];
                d = shadow_rows[dot_row-1][3*orcs_pkg::WordW-1:2*orcs_pkg::WordW];
                shadow_rows[dot_row-1][orcs_pkg::WordW-1:0] = (b & (a | c | d)) | (a & c & d);
                shadow_rows[dot_row]   = shadow_rows[dot_row-1];
                shadow_rows[dot_row-2] = shadow_rows[dot_row-1];
              end
              merge_read_row(dot_row);
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [orcs_pkg::DataW-1:0] want;
    if (!rst_ni) begin
      foreach (shadow_rows[i]) shadow_rows[i] = '0;
      expected_bytes.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      // Handle the result first so that a stray one is never masked by a new item.
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected read_byte 0x%02h", rsp_i.read_byte));
        end else begin
          want = expected_bytes.pop_front();
          if (rsp_i.read_byte !== want) begin
            report_mismatch($sformatf("read_byte 0x%02h, want 0x%02h", rsp_i.read_byte, want));
          end
        end
        results_seen++;
      end
      if (req_i.valid && req_i.ready) begin
        apply_item(want);
        expected_bytes.push_back(want);
      end
      pending_o    <= expected_bytes.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

>>> verif/tb_oam_row_corruption_store_unit.sv
// Testbench top: directed and random items into the sprite attribute row store, with verdict.
`timescale 1ns / 1ps
module tb_oam_row_corruption_store_unit;

  localparam int unsigned ROW_COUNT   = 20;
  localparam int unsigned StoreBytes  = ROW_COUNT * 8;
  localparam int unsigned RandomItems = 1550;
  localparam int unsigned CalmTail    = 200;
  localparam int unsigned PhaseItems  = 50;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned DrainCycles = 16;

  // Codes the block does not define; it must treat them as no-ops.
  localparam logic [orcs_pkg::KindW-1:0]  KindSpare = 2'd3;
  localparam logic [orcs_pkg::CtypeW-1:0] CtSpare   = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  bit          gaps_on   = 1'b0;
  bit          stalls_on = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned fail_count;
  int unsigned pending_count;

  orcs_req_if req_if ();
  orcs_rsp_if rsp_if ();

  oam_row_corruption_store_unit #(
    .ROW_COUNT(ROW_COUNT)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  orcs_row_checker #(
    .ROW_COUNT(ROW_COUNT)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .fail_count_o(fail_count),
    .pending_o   (pending_count)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: hold ready low in random bursts while stalls are enabled.
  initial begin
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  task automatic send_item(input logic [orcs_pkg::KindW-1:0] kind,
                           input logic [orcs_pkg::ByteIdxW-1:0] idx,
                           input logic [orcs_pkg::DataW-1:0] data, input logic locked,
                           input logic [orcs_pkg::CtypeW-1:0] ctype, input logic scan,
                           input logic [orcs_pkg::DotW-1:0] dot);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.kind         <= kind;
    req_if.byte_index   <= idx;
    req_if.write_byte   <= data;
    req_if.bus_locked   <= locked;
    req_if.corrupt_type <= ctype;
    req_if.scan_active  <= scan;
    req_if.line_dot     <= dot;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // Mostly well-formed accesses and live corruptions, with some raw noise.
  task automatic send_random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_item(orcs_pkg::KindWrite, orcs_pkg::ByteIdxW'($urandom_range(0, StoreBytes - 1)),
                orcs_pkg::DataW'($urandom), 1'b0, orcs_pkg::CtypeW'($urandom),
                1'($urandom), orcs_pkg::DotW'($urandom));
    end else if (pick < 60) begin
      send_item(orcs_pkg::KindRead, orcs_pkg::ByteIdxW'($urandom_range(0, StoreBytes - 1)),
                orcs_pkg::DataW'($urandom), 1'b0, orcs_pkg::CtypeW'($urandom),
                1'($urandom), orcs_pkg::DotW'($urandom));
    end else if (pick < 88) begin
      send_item(orcs_pkg::KindCorrupt, orcs_pkg::ByteIdxW'($urandom),
                orcs_pkg::DataW'($urandom), 1'($urandom),
                orcs_pkg::CtypeW'($urandom_range(0, 2)), 1'b1,
                orcs_pkg::DotW'($urandom_range(4, 79)));
    end else begin
      send_item(orcs_pkg::KindW'($urandom), orcs_pkg::ByteIdxW'($urandom),
                orcs_pkg::DataW'($urandom), 1'($urandom), orcs_pkg::CtypeW'($urandom),
                1'($urandom), orcs_pkg::DotW'($urandom));
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    req_if.valid        <= 1'b0;
    req_if.kind         <= orcs_pkg::KindRead;
    req_if.byte_index   <= '0;
    req_if.write_byte   <= '0;
    req_if.bus_locked   <= 1'b0;
    req_if.corrupt_type <= orcs_pkg::CtWrite;
    req_if.scan_active  <= 1'b0;
    req_if.line_dot     <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    send_item(orcs_pkg::KindRead, 8'd0, 8'h00, 1'b0, orcs_pkg::CtWrite, 1'b0, 7'd0);
    send_item(orcs_pkg::KindWrite, 8'd0, 8'hFF, 1'b0, orcs_pkg::CtWrite, 1'b0, 7'd0);
    send_item(orcs_pkg::KindWrite, orcs_pkg::ByteIdxW'(StoreBytes - 1), 8'hA5, 1'b0,
              orcs_pkg::CtWrite, 1'b0, 7'd0);
    send_item(orcs_pkg::KindWrite, 8'd16, 8'h81, 1'b0, orcs_pkg::CtWrite, 1'b0, 7'd0);
    send_item(orcs_pkg::KindWrite, 8'd28, 8'h7E, 1'b0, orcs_pkg::CtWrite, 1'b0, 7'd0);
    send_item(orcs_pkg::KindRead, 8'd0, 8'h00, 1'b0, orcs_pkg::CtWrite, 1'b0, 7'd0);
    send_item(orcs_pkg::KindRead, orcs_pkg::ByteIdxW'(StoreBytes - 1), 8'h00, 1'b0,
              orcs_pkg::CtWrite, 1'b0, 7'd0);
    // Locked: drop the write, return 0xFF on the read.
    send_item(orcs_pkg::KindWrite, 8'd8, 8'h5A, 1'b1, orcs_pkg::CtWrite, 1'b0, 7'd0);
    send_item(orcs_pkg::KindRead, 8'd8, 8'h00, 1'b0, orcs_pkg::CtWrite, 1'b0, 7'd0);
    send_item(orcs_pkg::KindRead, 8'd0, 8'h00, 1'b1, orcs_pkg::CtWrite, 1'b0, 7'd0);
    // Past the end of the store.
    send_item(orcs_pkg::KindRead, orcs_pkg::ByteIdxW'(StoreBytes), 8'h00, 1'b0,
              orcs_pkg::CtWrite, 1'b0, 7'd0);
    send_item(orcs_pkg::KindWrite, 8'hFF, 8'h3C, 1'b0, orcs_pkg::CtWrite, 1'b0, 7'd0);
    send_item(orcs_pkg::KindRead, 8'hFF, 8'h00, 1'b0, orcs_pkg::CtWrite, 1'b0, 7'd0);
    // Corruptions and a spare kind that must change nothing.
    send_item(orcs_pkg::KindCorrupt, 8'd0, 8'h00, 1'b0, orcs_pkg::CtWrite, 1'b0, 7'd8);
    send_item(orcs_pkg::KindCorrupt, 8'd0, 8'h00, 1'b0, orcs_pkg::CtRead, 1'b1, 7'd3);
    send_item(orcs_pkg::KindCorrupt, 8'd0, 8'h00, 1'b0, orcs_pkg::CtWrite, 1'b1, 7'h7F);
    send_item(orcs_pkg::KindCorrupt, 8'd0, 8'h00, 1'b0, orcs_pkg::CtRead, 1'b1, 7'd80);
    send_item(orcs_pkg::KindCorrupt, 8'd0, 8'h00, 1'b0, CtSpare, 1'b1, 7'd8);
    send_item(KindSpare, 8'hFF, 8'hFF, 1'b1, CtSpare, 1'b1, 7'h7F);
    // Live corruptions; the lock must not stop them.
    send_item(orcs_pkg::KindCorrupt, 8'd0, 8'h00, 1'b1, orcs_pkg::CtWrite, 1'b1, 7'd8);
    send_item(orcs_pkg::KindCorrupt, 8'd0, 8'h00, 1'b0, orcs_pkg::CtRead, 1'b1, 7'd79);
    send_item(orcs_pkg::KindCorrupt, 8'd0, 8'h00, 1'b0, orcs_pkg::CtReadInc, 1'b1, 7'd16);
    send_item(orcs_pkg::KindCorrupt, 8'd0, 8'h00, 1'b0, orcs_pkg::CtReadInc, 1'b1, 7'd72);
    send_item(orcs_pkg::KindCorrupt, 8'd0, 8'h00, 1'b0, orcs_pkg::CtReadInc, 1'b1, 7'd76);
    send_item(orcs_pkg::KindCorrupt, 8'd0, 8'h00, 1'b0, orcs_pkg::CtReadInc, 1'b1, 7'd12);

    for (int n = 0; n < RandomItems; n++) begin
      if (n % PhaseItems == 0) begin
        gaps_on   = (n < RandomItems - CalmTail) && ($urandom_range(0, 2) != 0);
        stalls_on = (n < RandomItems - CalmTail) && ($urandom_range(0, 2) != 0);
      end
      send_random_item();
    end
    req_if.valid <= 1'b0;

    // Let the checker register the last item before polling the count of outstanding results.
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
